FILE: rtl/dilated_five_tap_smoother_unit_macros.svh
// ----------------------------------------------------------------------------
// dilated five-tap smoother: assertion macros
// concurrent assertion wrappers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef DILATED_FIVE_TAP_SMOOTHER_UNIT_MACROS_SVH
`define DILATED_FIVE_TAP_SMOOTHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define DFTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked in reset too
`define DFTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DFTS_ASSERT(lbl, prop, msg)
`define DFTS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/dfts_pkg.sv
// ----------------------------------------------------------------------------
// dfts_pkg
// types, constants and helpers shared by the smoother modules
// ----------------------------------------------------------------------------
package dfts_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int IMG_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int IMG_AW     = $clog2(IMG_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int COORD_W  = 6;
    localparam int EXT_W    = 7;
    localparam int STEP_W   = 6;
    localparam int CFG_IW   = 3;
    localparam int TAP_KW   = 3;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + 3;

    localparam logic [TAP_KW-1:0] LAST_TAP = TAP_KW'(4);

    typedef enum logic [CFG_IW-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_DILATION_STEP = 3'd2,
        CFG_ALONG_COLUMNS = 3'd3,
        CFG_CLAMP_BORDER  = 3'd4,
        CFG_OUTER_TAP     = 3'd5,
        CFG_NEAR_TAP      = 3'd6,
        CFG_CENTRE_TAP    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                func;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoothed;
        logic                out_of_range;
    } t_out;

    typedef struct packed {
        logic              load;
        logic              wr;
        logic              clr_acc;
        logic              rd_en;
        logic [TAP_KW-1:0] rd_k;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic filter;
    } t_status;

    function automatic logic [EXT_W-1:0] used_extent(input logic [EXT_W-1:0] cfg,
                                                     input int limit);
        logic [EXT_W-1:0] ext;
        if (int'(cfg) > limit) begin
            ext = EXT_W'(limit);
        end else begin
            ext = cfg;
        end
        return ext;
    endfunction

    function automatic logic [IMG_AW-1:0] pixel_addr(input logic [EXT_W-1:0] row,
                                                     input logic [EXT_W-1:0] col);
        logic [IMG_AW-1:0] base;
        base = IMG_AW'(row) * IMG_AW'(MAX_WIDTH);
        return base + IMG_AW'(col);
    endfunction

endpackage

FILE: rtl/dfts_ram.sv
// ----------------------------------------------------------------------------
// dfts_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module dfts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dfts_ctrl.sv
// ----------------------------------------------------------------------------
// dfts_ctrl
// item sequencer: range check, store write, five tap reads, result hand-off
// ----------------------------------------------------------------------------
`include "dilated_five_tap_smoother_unit_macros.svh"

module dfts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  dfts_pkg::t_status i_status,
    output dfts_pkg::t_cmd    o_cmd
);
    import dfts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [TAP_KW-1:0] r_k, n_k;
    logic              r_drain, n_drain;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    t_cmd              cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_drain     = r_drain;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        cmd.rd_k    = r_k;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.clr_acc = 1'b1;
                n_k         = '0;
                if (i_status.oor || !i_status.filter) begin
                    cmd.wr  = !i_status.oor;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                n_k       = r_k + TAP_KW'(1);
                if (r_k == LAST_TAP) begin
                    n_drain = 1'b0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `DFTS_ASSERT(a_accept_then_busy, (i_in_valid && !o_in_stall) |=> o_in_stall, "accept not followed by busy")
    `DFTS_ASSERT(a_no_overwrite, cmd.out_load |-> out_free, "result register overwritten")
    `DFTS_ASSERT(a_read_in_range, cmd.rd_en |-> (r_k <= LAST_TAP), "tap index beyond last tap")
    `DFTS_ASSERT(a_drain_length, (r_state == ST_READ && r_k == LAST_TAP) |-> ##3 (r_state == ST_DONE), "drain length wrong")
    `DFTS_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

FILE: rtl/dfts_dp.sv
// ----------------------------------------------------------------------------
// dfts_dp
// datapath: config registers, tap addressing, image store, multiply-accumulate
// ----------------------------------------------------------------------------
module dfts_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr,
    input  logic [dfts_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    input  dfts_pkg::t_in               i_in_data,
    input  dfts_pkg::t_cmd              i_cmd,
    output dfts_pkg::t_status           o_status,
    output dfts_pkg::t_out              o_out_data
);
    import dfts_pkg::*;

    logic [EXT_W-1:0]    r_width, r_height;
    logic [STEP_W-1:0]   r_step;
    logic                r_along, r_clamp;
    logic [SAMPLE_W-1:0] r_outer, r_near, r_centre;

    t_in                 r_item;
    t_out                r_out;

    logic [EXT_W-1:0]    w, h, n, tap_pos, rd_row, rd_col;
    logic [COORD_W-1:0]  centre;
    logic signed [8:0]   pos, c9, s9, s29, n9;
    logic                outside, oor;
    logic [IMG_AW-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] rdata, weight;

    logic                r_v1, r_zero1, r_v2;
    logic [TAP_KW-1:0]   r_k1;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc, rounded_sum;
    logic [ACC_W-17:0]   rnd;
    logic [SAMPLE_W-1:0] smoothed;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= EXT_W'(64);
            r_height <= EXT_W'(64);
            r_step   <= STEP_W'(1);
            r_along  <= 1'b0;
            r_clamp  <= 1'b0;
            r_outer  <= 16'd4096;
            r_near   <= 16'd16384;
            r_centre <= 16'd24576;
        end else if (i_cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[EXT_W-1:0];
                CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[EXT_W-1:0];
                CFG_DILATION_STEP: r_step   <= i_cfg_data[STEP_W-1:0];
                CFG_ALONG_COLUMNS: r_along  <= i_cfg_data[0];
                CFG_CLAMP_BORDER:  r_clamp  <= i_cfg_data[0];
                CFG_OUTER_TAP:     r_outer  <= i_cfg_data;
                CFG_NEAR_TAP:      r_near   <= i_cfg_data;
                CFG_CENTRE_TAP:    r_centre <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
    end

    // range check
    always_comb begin
        w   = used_extent(r_width, MAX_WIDTH);
        h   = used_extent(r_height, MAX_HEIGHT);
        oor = ({1'b0, r_item.col} >= w) || ({1'b0, r_item.row} >= h);
    end

    assign o_status.oor    = oor;
    assign o_status.filter = r_item.func;

    // tap position along the filter axis
    always_comb begin
        n      = r_along ? h : w;
        centre = r_along ? r_item.row : r_item.col;
        c9     = $signed({3'b000, centre});
        s9     = $signed({3'b000, r_step});
        s29    = $signed({2'b00, r_step, 1'b0});
        n9     = $signed({2'b00, n});
        case (i_cmd.rd_k)
            3'd0:    pos = c9 - s29;
            3'd1:    pos = c9 - s9;
            3'd3:    pos = c9 + s9;
            3'd4:    pos = c9 + s29;
            default: pos = c9;
        endcase
        outside = (pos < 0) || (pos >= n9);
        if (pos < 0) begin
            tap_pos = '0;
        end else if (outside) begin
            tap_pos = n - EXT_W'(1);
        end else begin
            tap_pos = pos[EXT_W-1:0];
        end
        rd_row = r_along ? tap_pos : {1'b0, r_item.row};
        rd_col = r_along ? {1'b0, r_item.col} : tap_pos;
        if (i_cmd.wr) begin
            ram_addr = pixel_addr({1'b0, r_item.row}, {1'b0, r_item.col});
        end else begin
            ram_addr = pixel_addr(rd_row, rd_col);
        end
    end

    dfts_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (IMG_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_addr  (ram_addr),
        .i_wdata (r_item.sample),
        .o_rdata (rdata)
    );

    // multiply-accumulate
    always_comb begin
        case (r_k1)
            3'd0, 3'd4: weight = r_outer;
            3'd1, 3'd3: weight = r_near;
            default:    weight = r_centre;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero1 <= outside && !r_clamp;
        r_k1    <= i_cmd.rd_k;
        r_prod  <= r_zero1 ? '0 : rdata * weight;
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round to nearest, saturate
    always_comb begin
        rounded_sum = r_acc + ACC_W'(32768);
        rnd         = rounded_sum[ACC_W-1:16];
        if (|rnd[ACC_W-17:SAMPLE_W]) begin
            smoothed = '1;
        end else begin
            smoothed = rnd[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_of_range <= oor;
            r_out.smoothed     <= (oor || !r_item.func) ? '0 : smoothed;
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/dilated_five_tap_smoother_unit.sv
// ----------------------------------------------------------------------------
// dilated_five_tap_smoother_unit
// image store with a dilated symmetric five-tap smoother on read
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall / i_in_data, a transfer happens on a
//   rising edge with valid high and stall low; func 0 stores a sample at
//   (col,row), func 1 filters at (col,row)
// output channel: o_out_valid / i_out_stall / o_out_data, one result per item
// config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
//   the register, write only while the unit is idle
// store or out-of-range item: the check state, with the write for a store, then
//   the result is loaded in the done state; filter item: the check state, five
//   reads through the single-port image store, one per cycle, then the
//   two-stage multiply-accumulate drains and the result is loaded in the done
//   state
// one item in flight; a finished result sits in the output register, so the
//   next item is taken while it waits, and the unit holds before a second
//   result if the receiver keeps stalling
// reset: synchronous; config registers return to their defaults, the output
//   register empties, the image store keeps its contents and is undefined
//   until written
// ----------------------------------------------------------------------------
module dilated_five_tap_smoother_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dfts_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dfts_pkg::t_out              o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dfts_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);
    import dfts_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dfts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dfts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: tb/sv/dilated_five_tap_smoother_unit_tb.sv
// ----------------------------------------------------------------------------
// dilated_five_tap_smoother_unit_tb
// self-checking bench for the dilated five-tap smoother: a short directed run
// over borders, saturation, rounding, size and step extremes, then random
// store and filter traffic under many register settings with random idle and
// stall bursts; every result is checked against an in-bench model of the
// image store and the rounded, saturated five-tap sum
// ----------------------------------------------------------------------------
module dilated_five_tap_smoother_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfts_pkg::*;

    localparam logic FUNC_STORE    = 1'b0;
    localparam logic FUNC_FILTER   = 1'b1;
    localparam int   CYCLE_LIMIT   = 500_000;
    localparam int   PHASE_ITEMS   = 125;
    localparam int   RANDOM_PHASES = 12;
    localparam int   TAIL_CYCLES   = 20;

    typedef struct packed {
        logic [EXT_W-1:0]    width;
        logic [EXT_W-1:0]    height;
        logic [STEP_W-1:0]   step;
        logic                along;
        logic                clamp;
        logic [SAMPLE_W-1:0] outer_w;
        logic [SAMPLE_W-1:0] near_w;
        logic [SAMPLE_W-1:0] centre_w;
    } t_smoother_setup;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [15:0]       i_cfg_data  = '0;

    // model of the unit: registers, image store and which entries hold data
    t_smoother_setup     setup = t_smoother_setup'{width: 7'd64, height: 7'd64,
                                                   step: 6'd1, along: 1'b0, clamp: 1'b0,
                                                   outer_w: 16'd4096, near_w: 16'd16384,
                                                   centre_w: 16'd24576};
    logic [SAMPLE_W-1:0] image_copy [IMG_DEPTH];
    bit                  written    [IMG_DEPTH];

    t_out        awaited[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int unsigned idle_pct   = 0;
    int unsigned stall_left = 0;
    int          cycles     = 0;

    dilated_five_tap_smoother_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int clip(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic bit in_range(input int col, input int row);
        return col < clip(setup.width, MAX_WIDTH) && row < clip(setup.height, MAX_HEIGHT);
    endfunction

    // store address read by tap k (offset k*step), -1 where the tap reads zero
    function automatic int tap_addr(input int col, input int row, input int k);
        int n;
        int pos;
        n   = setup.along ? clip(setup.height, MAX_HEIGHT) : clip(setup.width, MAX_WIDTH);
        pos = (setup.along ? row : col) + k * int'(setup.step);
        if (pos < 0 || pos >= n) begin
            if (!setup.clamp) begin
                return -1;
            end
            pos = (pos < 0) ? 0 : n - 1;
        end
        return setup.along ? pos * MAX_WIDTH + col : row * MAX_WIDTH + pos;
    endfunction

    function automatic t_out smooth_result(input t_in item);
        t_out                res;
        longint unsigned     acc;
        int                  a;
        logic [SAMPLE_W-1:0] weight;
        res = '0;
        acc = 0;
        if (!in_range(item.col, item.row)) begin
            res.out_of_range = 1'b1;
        end else if (item.func == FUNC_STORE) begin
            a = int'(item.row) * MAX_WIDTH + int'(item.col);
            image_copy[a] = item.sample;
            written[a]    = 1'b1;
        end else begin
            for (int k = -2; k <= 2; k++) begin
                a = tap_addr(item.col, item.row, k);
                if (k == 0) begin
                    weight = setup.centre_w;
                end else if (k == 1 || k == -1) begin
                    weight = setup.near_w;
                end else begin
                    weight = setup.outer_w;
                end
                if (a >= 0) begin
                    acc += 64'(image_copy[a]) * 64'(weight);
                end
            end
            acc = (acc + 64'd32768) >> 16;
            res.smoothed = (acc > 64'd65535) ? 16'hFFFF : SAMPLE_W'(acc);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_item(input t_in item);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        awaited.push_back(smooth_result(item));
        items_sent++;
    endtask

    task automatic store_at(input int col, input int row, input logic [SAMPLE_W-1:0] value);
        t_in item;
        item.func   = FUNC_STORE;
        item.col    = COORD_W'(col);
        item.row    = COORD_W'(row);
        item.sample = value;
        send_item(item);
    endtask

    // for an in-range item, writes any tap that was never written, then filters
    task automatic filter_at(input int col, input int row);
        t_in item;
        int  a;
        if (in_range(col, row)) begin
            for (int k = -2; k <= 2; k++) begin
                a = tap_addr(col, row, k);
                if (a >= 0 && !written[a]) begin
                    store_at(a % MAX_WIDTH, a / MAX_WIDTH, SAMPLE_W'($urandom()));
                end
            end
        end
        item.func   = FUNC_FILTER;
        item.col    = COORD_W'(col);
        item.row    = COORD_W'(row);
        item.sample = SAMPLE_W'($urandom());
        send_item(item);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:   setup.width    = EXT_W'(value);
            CFG_IMAGE_HEIGHT:  setup.height   = EXT_W'(value);
            CFG_DILATION_STEP: setup.step     = STEP_W'(value);
            CFG_ALONG_COLUMNS: setup.along    = value[0];
            CFG_CLAMP_BORDER:  setup.clamp    = value[0];
            CFG_OUTER_TAP:     setup.outer_w  = value;
            CFG_NEAR_TAP:      setup.near_w   = value;
            CFG_CENTRE_TAP:    setup.centre_w = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_smoother_setup s);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'(s.width));
        write_reg(CFG_IMAGE_HEIGHT, 16'(s.height));
        write_reg(CFG_DILATION_STEP, 16'(s.step));
        write_reg(CFG_ALONG_COLUMNS, 16'(s.along));
        write_reg(CFG_CLAMP_BORDER, 16'(s.clamp));
        write_reg(CFG_OUTER_TAP, s.outer_w);
        write_reg(CFG_NEAR_TAP, s.near_w);
        write_reg(CFG_CENTRE_TAP, s.centre_w);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [EXT_W-1:0] random_extent();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return EXT_W'($urandom_range(65, 127));
        end else if (pick == 1) begin
            return EXT_W'(64);
        end else if (pick < 4) begin
            return EXT_W'($urandom_range(17, 63));
        end
        return EXT_W'($urandom_range(1, 16));
    endfunction

    function automatic t_smoother_setup random_setup();
        t_smoother_setup s;
        int unsigned     pick;
        s.width  = random_extent();
        s.height = random_extent();
        pick     = $urandom_range(0, 5);
        if (pick == 0) begin
            s.step = '0;
        end else if (pick == 1) begin
            s.step = STEP_W'($urandom_range(8, 63));
        end else begin
            s.step = STEP_W'($urandom_range(1, 4));
        end
        s.along = 1'($urandom_range(0, 1));
        s.clamp = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
            s.outer_w  = SAMPLE_W'($urandom());
            s.near_w   = SAMPLE_W'($urandom());
            s.centre_w = SAMPLE_W'($urandom());
        end else begin
            s.outer_w  = SAMPLE_W'($urandom_range(0, 8192));
            s.near_w   = SAMPLE_W'($urandom_range(0, 20000));
            s.centre_w = SAMPLE_W'($urandom_range(0, 30000));
        end
        return s;
    endfunction

    task automatic random_phase(input int count);
        int stop;
        int col;
        int row;
        int w;
        int h;
        stop = items_sent + count;
        w    = clip(setup.width, MAX_WIDTH);
        h    = clip(setup.height, MAX_HEIGHT);
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                col = $urandom_range(0, 63);
                row = $urandom_range(0, 63);
            end else begin
                col = $urandom_range(0, w - 1);
                row = $urandom_range(0, h - 1);
            end
            if ($urandom_range(0, 1) == 0) begin
                store_at(col, row, SAMPLE_W'($urandom()));
            end else begin
                filter_at(col, row);
            end
        end
    endtask

    // reset values: zero border at both image ends
    task automatic test_default_settings();
        idle_pct = 30;
        store_at(0, 0, 16'hFFFF);
        store_at(1, 0, 16'h0000);
        store_at(2, 0, 16'h8000);
        filter_at(0, 0);
        store_at(63, 63, 16'hFFFF);
        filter_at(63, 63);
    endtask

    // full weights with step zero, coordinates past the size, zero size
    task automatic test_saturation_and_range();
        load_settings(t_smoother_setup'{width: 7'd8, height: 7'd4, step: 6'd0,
                                        along: 1'b1, clamp: 1'b1, outer_w: 16'hFFFF,
                                        near_w: 16'hFFFF, centre_w: 16'hFFFF});
        store_at(7, 3, 16'hFFFF);
        filter_at(7, 3);
        store_at(8, 0, 16'h1234);
        filter_at(0, 4);
        store_at(63, 63, 16'h5555);
        load_settings(t_smoother_setup'{width: 7'd0, height: 7'd64, step: 6'd63,
                                        along: 1'b0, clamp: 1'b1, outer_w: 16'h0000,
                                        near_w: 16'h0000, centre_w: 16'h0000});
        store_at(0, 0, 16'h0001);
        filter_at(0, 0);
    endtask

    // clamped row taps with the widest step and an oversize width, then
    // zero-border column taps; half-way rounding on the centre tap
    task automatic test_clamped_edges();
        load_settings(t_smoother_setup'{width: 7'd127, height: 7'd1, step: 6'd63,
                                        along: 1'b0, clamp: 1'b1, outer_w: 16'd1,
                                        near_w: 16'd0, centre_w: 16'h8000});
        store_at(5, 0, 16'h0001);
        filter_at(5, 0);
        load_settings(t_smoother_setup'{width: 7'd16, height: 7'd16, step: 6'd3,
                                        along: 1'b1, clamp: 1'b0, outer_w: 16'd4096,
                                        near_w: 16'd16384, centre_w: 16'd24576});
        store_at(2, 4, 16'h8000);
        filter_at(2, 1);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_settings(random_setup());
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            random_phase(PHASE_ITEMS);
        end
    endtask

    task automatic test_unthrottled_tail();
        load_settings(random_setup());
        idle_pct = 0;
        random_phase(PHASE_ITEMS);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || idle_pct == 0) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left  <= $urandom_range(1, 4);
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_out_data));
            end else begin
                want = awaited.pop_front();
                if (o_out_data.smoothed !== want.smoothed) begin
                    report_mismatch($sformatf("smoothed got %h want %h",
                                              o_out_data.smoothed, want.smoothed));
                end
                if (o_out_data.out_of_range !== want.out_of_range) begin
                    report_mismatch($sformatf("out_of_range got %b want %b",
                                              o_out_data.out_of_range, want.out_of_range));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_settings();
        test_saturation_and_range();
        test_clamped_edges();
        test_random_settings();
        test_unthrottled_tail();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
